// ===== design/vsc_pkg.sv =====
// Shared types, constants and helpers for the voxel surface counter.
package vsc_pkg;

  // Grid storage limits
  localparam int unsigned MAX_X = 32;
  localparam int unsigned MAX_Y = 32;
  localparam int unsigned MAX_Z = 32;
  localparam int unsigned Depth = MAX_X * MAX_Y * MAX_Z;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  // Field widths
  localparam int unsigned ExtW   = 6;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CoordW = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 32;

  // Operation codes
  localparam logic [FuncW-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FuncW-1:0] FUNC_READ  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_COUNT = 2'd2;

  // Voxel kinds
  localparam logic [KindW-1:0] KIND_AIR = 3'd0;
  localparam logic [KindW-1:0] KIND_TOP = 3'd4;

  // Register indexes (word address paddr[3:2])
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DEPTH  = 2'd2;

  localparam logic [ExtW-1:0] ExtReset = 6'd32;

  // Grid extents in use, already clamped to the storage limits
  typedef struct packed {
    logic [ExtW-1:0] w;
    logic [ExtW-1:0] h;
    logic [ExtW-1:0] d;
  } ext_t;

  function automatic logic [ExtW-1:0] vsc_clamp(logic [ExtW-1:0] r, int unsigned m);
    return (32'(r) > m) ? ExtW'(m) : r;
  endfunction

  // Store layout: ((y * MAX_Z + z) * MAX_X + x)
  function automatic logic [AddrW-1:0] vsc_addr(logic [ExtW-1:0] x, logic [ExtW-1:0] y,
                                                logic [ExtW-1:0] z);
    return AddrW'((32'(y) * MAX_Z + 32'(z)) * MAX_X + 32'(x));
  endfunction

endpackage

// ===== design/vsc_ram.sv =====
// Generic simple dual-port RAM with registered read.
module vsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/vsc_regs.sv =====
// APB-style configuration registers holding the grid extents.
module vsc_regs import vsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output ext_t              ext_o
);

  logic [ExtW-1:0] width_q, height_q, depth_q;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ExtReset;
      height_q <= ExtReset;
      depth_q  <= ExtReset;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_q  <= pwdata[ExtW-1:0];
        REG_HEIGHT: height_q <= pwdata[ExtW-1:0];
        REG_DEPTH:  depth_q  <= pwdata[ExtW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = PdataW'(width_q);
      REG_HEIGHT: prdata = PdataW'(height_q);
      REG_DEPTH:  prdata = PdataW'(depth_q);
      default:    prdata = '0;
    endcase
  end

  // Values above the storage limits act as the limit
  assign ext_o.w = vsc_clamp(width_q, MAX_X);
  assign ext_o.h = vsc_clamp(height_q, MAX_Y);
  assign ext_o.d = vsc_clamp(depth_q, MAX_Z);

endmodule

// ===== design/voxel_surface_counter_core.sv =====
// Voxel grid with write, read and 6-neighbor surface count over one shared RAM read port.
// A write needs no RAM read, a read one RAM read, a count one RAM read per probe:
//   a center probe and up to six neighbor probes per voxel.
// Throughput: one item at a time; in_ready_o is low during a read, a count or a held result.
// Reset: asynchronous, active low; afterwards a clearing pass writes air to all 32768
//   entries, one per cycle, with in_ready_o low (configuration writes still taken).
module voxel_surface_counter_core import vsc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // APB-style configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PaddrW-1:0]        paddr,
  input  logic [PdataW-1:0]        pwdata,
  output logic [PdataW-1:0]        prdata,
  output logic                     pready,
  // Input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [FuncW-1:0]         func_i,
  input  logic signed [CoordW-1:0] coord_x_i,
  input  logic signed [CoordW-1:0] coord_y_i,
  input  logic signed [CoordW-1:0] coord_z_i,
  input  logic [KindW-1:0]         voxel_kind_i,
  // Output channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     in_range_o,
  output logic [KindW-1:0]         read_kind_o,
  output logic [CountW-1:0]        surface_count_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // Probe order: center, then +x, -x, +y, -y, +z, -z
  localparam logic [2:0] P_CTR = 3'd0;
  localparam logic [2:0] P_XP  = 3'd1;
  localparam logic [2:0] P_XM  = 3'd2;
  localparam logic [2:0] P_YP  = 3'd3;
  localparam logic [2:0] P_YM  = 3'd4;
  localparam logic [2:0] P_ZP  = 3'd5;
  localparam logic [2:0] P_ZM  = 3'd6;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  function automatic logic fits_next(logic [ExtW-1:0] a, logic [ExtW-1:0] lim);
    return ((ExtW+1)'(a) + (ExtW+1)'(1)) < (ExtW+1)'(lim);
  endfunction

  ext_t ext;

  logic [2:0]        state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [ExtW-1:0]   cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [2:0]        p_q, p_d;
  logic [CountW-1:0] cnt_q, cnt_d;

  logic              hold_range_q;
  logic [KindW-1:0]  hold_kind_q;
  logic [CountW-1:0] hold_count_q;
  logic              out_valid_q, out_range_q;
  logic [KindW-1:0]  out_kind_q;
  logic [CountW-1:0] out_count_q;

  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [KindW-1:0]  ram_wdata, ram_rdata;

  logic              in_ok;
  logic [AddrW-1:0]  in_addr;
  logic [ExtW-1:0]   px, py, pz;
  logic              p_ok;
  logic              emit, hit, next_vox, slot_free, out_load, hold_load;
  logic              res_range;
  logic [KindW-1:0]  res_kind;
  logic [CountW-1:0] res_count;

  vsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ext_o   (ext)
  );

  vsc_ram #(
    .WIDTH (KindW),
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Input coordinate check; in range implies each coordinate fits ExtW bits
  assign in_ok = !coord_x_i[CoordW-1] && !coord_y_i[CoordW-1] && !coord_z_i[CoordW-1] &&
                 ($unsigned(coord_x_i) < CoordW'(ext.w)) &&
                 ($unsigned(coord_y_i) < CoordW'(ext.h)) &&
                 ($unsigned(coord_z_i) < CoordW'(ext.d));
  assign in_addr = vsc_addr(coord_x_i[ExtW-1:0], coord_y_i[ExtW-1:0], coord_z_i[ExtW-1:0]);

  // Probe coordinate for the walk; p_ok low means the neighbor lies outside (air)
  always_comb begin
    px   = cx_q;
    py   = cy_q;
    pz   = cz_q;
    p_ok = 1'b1;
    unique case (p_q)
      P_CTR: ;
      P_XP: begin
        px   = cx_q + 1'b1;
        p_ok = fits_next(cx_q, ext.w);
      end
      P_XM: begin
        px   = cx_q - 1'b1;
        p_ok = (cx_q != '0);
      end
      P_YP: begin
        py   = cy_q + 1'b1;
        p_ok = fits_next(cy_q, ext.h);
      end
      P_YM: begin
        py   = cy_q - 1'b1;
        p_ok = (cy_q != '0);
      end
      P_ZP: begin
        pz   = cz_q + 1'b1;
        p_ok = fits_next(cz_q, ext.d);
      end
      P_ZM: begin
        pz   = cz_q - 1'b1;
        p_ok = (cz_q != '0);
      end
      default: p_ok = 1'b0;
    endcase
  end

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    cz_d      = cz_q;
    p_d       = p_q;
    cnt_d     = cnt_q;
    ram_we    = 1'b0;
    ram_waddr = in_addr;
    ram_wdata = voxel_kind_i;
    ram_re    = 1'b0;
    ram_raddr = in_addr;
    emit      = 1'b0;
    hit       = 1'b0;
    next_vox  = 1'b0;
    res_range = 1'b0;
    res_kind  = KIND_AIR;
    res_count = '0;
    out_load  = 1'b0;
    hold_load = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = KIND_AIR;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LastAddr) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (func_i)
            FUNC_WRITE: begin
              emit      = 1'b1;
              res_range = in_ok;
              // kinds above the top code are dropped
              ram_we    = in_ok && (voxel_kind_i <= KIND_TOP);
            end
            FUNC_READ: begin
              if (in_ok) begin
                ram_re  = 1'b1;
                state_d = S_READ;
              end else begin
                emit = 1'b1;
              end
            end
            FUNC_COUNT: begin
              if (ext.w == '0 || ext.h == '0 || ext.d == '0) begin
                emit = 1'b1;
              end else begin
                cx_d    = '0;
                cy_d    = '0;
                cz_d    = '0;
                p_d     = P_CTR;
                cnt_d   = '0;
                state_d = S_PROBE;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_READ: begin
        emit      = 1'b1;
        res_range = 1'b1;
        res_kind  = ram_rdata;
      end
      S_PROBE: begin
        if (p_ok) begin
          ram_re    = 1'b1;
          ram_raddr = vsc_addr(px, py, pz);
          state_d   = S_EVAL;
        end else begin
          hit      = 1'b1;
          next_vox = 1'b1;
        end
      end
      S_EVAL: begin
        if (p_q == P_CTR) begin
          if (ram_rdata == KIND_AIR) begin
            next_vox = 1'b1;
          end else begin
            p_d     = P_XP;
            state_d = S_PROBE;
          end
        end else if (ram_rdata == KIND_AIR) begin
          hit      = 1'b1;
          next_vox = 1'b1;
        end else if (p_q == P_ZM) begin
          next_vox = 1'b1;
        end else begin
          p_d     = p_q + 1'b1;
          state_d = S_PROBE;
        end
      end
      S_DONE: begin
        emit      = 1'b1;
        res_range = hold_range_q;
        res_kind  = hold_kind_q;
        res_count = hold_count_q;
      end
      default: state_d = S_IDLE;
    endcase

    // Saturating surface tally
    if (hit && cnt_q != '1) begin
      cnt_d = cnt_q + 1'b1;
    end

    // Step to the next voxel: x fastest, then y, then z
    if (next_vox) begin
      p_d     = P_CTR;
      state_d = S_PROBE;
      if (fits_next(cx_q, ext.w)) begin
        cx_d = cx_q + 1'b1;
      end else begin
        cx_d = '0;
        if (fits_next(cy_q, ext.h)) begin
          cy_d = cy_q + 1'b1;
        end else begin
          cy_d = '0;
          if (fits_next(cz_q, ext.d)) begin
            cz_d = cz_q + 1'b1;
          end else begin
            emit      = 1'b1;
            res_count = cnt_d;
          end
        end
      end
    end

    // Result goes to the output register, or waits in the hold register
    if (emit) begin
      if (slot_free) begin
        out_load = 1'b1;
        state_d  = S_IDLE;
      end else begin
        hold_load = 1'b1;
        state_d   = S_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      cz_q        <= '0;
      p_q         <= P_CTR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      cz_q    <= cz_d;
      p_q     <= p_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_load) begin
      hold_range_q <= res_range;
      hold_kind_q  <= res_kind;
      hold_count_q <= res_count;
    end
    if (out_load) begin
      out_range_q <= res_range;
      out_kind_q  <= res_kind;
      out_count_q <= res_count;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign in_range_o      = out_range_q;
  assign read_kind_o     = out_kind_q;
  assign surface_count_o = out_count_q;

endmodule

// ===== design/vsc_checker.sv =====
// Port-level assertions for the voxel surface counter, bound to the top level.
module vsc_checker import vsc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              in_range_o,
  input logic [KindW-1:0]  read_kind_o,
  input logic [CountW-1:0] surface_count_o
);

  // A stalled result transfer keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(in_range_o) &&
      $stable(read_kind_o) && $stable(surface_count_o))
    else $error("result changed while stalled");

  // Kinds above the top code are never stored, so never read back
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> read_kind_o <= KIND_TOP)
    else $error("illegal voxel kind read");

  // A non-air kind only comes from an in-range read
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_kind_o != KIND_AIR |-> in_range_o)
    else $error("kind returned for out-of-range read");

  // A nonzero surface count belongs to a count result only
  a_count_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && surface_count_o != '0 |-> !in_range_o && read_kind_o == KIND_AIR)
    else $error("count mixed with read or write fields");

endmodule

bind voxel_surface_counter_core vsc_checker u_vsc_checker (.*);

// ===== tb/sv/tb_voxel_surface_counter_core.sv =====
// Self-checking testbench for voxel_surface_counter_core: voxel ops checked against a grid model.
module tb_voxel_surface_counter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import vsc_pkg::*;

  localparam logic [FuncW-1:0] FUNC_SPARE = 2'd3;
  localparam logic [KindW-1:0] KIND_GRASS = 3'd1;
  localparam logic [KindW-1:0] KIND_DIRT  = 3'd2;
  localparam logic [KindW-1:0] KIND_STONE = 3'd3;
  localparam logic [KindW-1:0] KIND_WATER = 3'd4;
  // a full-grid count walks 32768 voxels, each with a center probe and up to six neighbor probes
  localparam int STALL_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [FuncW-1:0]         func;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [KindW-1:0]         kind;
  } vox_op_t;

  typedef struct {
    logic              in_range;
    logic [KindW-1:0]  read_kind;
    logic [CountW-1:0] surface_count;
  } vox_answer_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PaddrW-1:0]        paddr = '0;
  logic [PdataW-1:0]        pwdata = '0;
  logic [PdataW-1:0]        prdata;
  logic                     pready;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [FuncW-1:0]         func_i = '0;
  logic signed [CoordW-1:0] coord_x_i = '0;
  logic signed [CoordW-1:0] coord_y_i = '0;
  logic signed [CoordW-1:0] coord_z_i = '0;
  logic [KindW-1:0]         voxel_kind_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic                     in_range_o;
  logic [KindW-1:0]         read_kind_o;
  logic [CountW-1:0]        surface_count_o;

  voxel_surface_counter_core u_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // grid model and extent registers as last written
  logic [KindW-1:0] grid_q [MAX_X][MAX_Y][MAX_Z];
  logic [ExtW-1:0]  width_reg = ExtReset;
  logic [ExtW-1:0]  height_reg = ExtReset;
  logic [ExtW-1:0]  depth_reg = ExtReset;

  vox_op_t     voxel_ops_q[$];
  vox_answer_t answer_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int quiet_cycles = 0;
  int n_errors = 0;
  int n_results = 0;
  int n_writes = 0;
  int n_reads = 0;
  int n_counts = 0;
  int n_spare = 0;
  int n_settings = 0;
  int max_surface = 0;

  function automatic int span(logic [ExtW-1:0] r, int unsigned lim);
    return (r > lim) ? int'(lim) : int'(r);
  endfunction

  function automatic bit in_grid(int x, int y, int z);
    return x >= 0 && y >= 0 && z >= 0 && x < span(width_reg, MAX_X) &&
           y < span(height_reg, MAX_Y) && z < span(depth_reg, MAX_Z);
  endfunction

  function automatic logic [KindW-1:0] kind_at(int x, int y, int z);
    if (!in_grid(x, y, z)) return KIND_AIR;
    return grid_q[x][y][z];
  endfunction

  function automatic logic [CountW-1:0] count_surface();
    int total = 0;
    for (int z = 0; z < span(depth_reg, MAX_Z); z++)
      for (int y = 0; y < span(height_reg, MAX_Y); y++)
        for (int x = 0; x < span(width_reg, MAX_X); x++)
          if (kind_at(x, y, z) != KIND_AIR &&
              (kind_at(x + 1, y, z) == KIND_AIR || kind_at(x - 1, y, z) == KIND_AIR ||
               kind_at(x, y + 1, z) == KIND_AIR || kind_at(x, y - 1, z) == KIND_AIR ||
               kind_at(x, y, z + 1) == KIND_AIR || kind_at(x, y, z - 1) == KIND_AIR) &&
              total < 65535)
            total++;
    return CountW'(total);
  endfunction

  function automatic vox_answer_t apply_voxel_op(vox_op_t op);
    vox_answer_t ans;
    bit hit;
    int x, y, z;
    x = int'(op.x);
    y = int'(op.y);
    z = int'(op.z);
    ans = '{in_range: 1'b0, read_kind: KIND_AIR, surface_count: '0};
    hit = in_grid(x, y, z);
    case (op.func)
      FUNC_WRITE: begin
        ans.in_range = hit;
        // kinds above water leave the cell as it was
        if (hit && op.kind <= KIND_TOP) grid_q[x][y][z] = op.kind;
      end
      FUNC_READ: begin
        ans.in_range = hit;
        ans.read_kind = kind_at(x, y, z);
      end
      FUNC_COUNT: ans.surface_count = count_surface();
      default: ;
    endcase
    return ans;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    n_errors++;
  endtask

  // sender
  always @(posedge clk_i) begin
    vox_op_t op;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (voxel_ops_q.size() != 0 && send_idle_pct != 0 &&
                   $urandom_range(99) < send_idle_pct) begin
        send_gap <= $urandom_range(5);
        in_valid_i <= 1'b0;
      end else if (voxel_ops_q.size() != 0) begin
        op = voxel_ops_q.pop_front();
        func_i <= op.func;
        coord_x_i <= op.x;
        coord_y_i <= op.y;
        coord_z_i <= op.z;
        voxel_kind_i <= op.kind;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      out_ready_i <= 1'b0;
    end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
      recv_gap <= $urandom_range(5);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // predict on input transfer, compare on output transfer
  always @(posedge clk_i) begin
    vox_answer_t want;
    vox_answer_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        got = apply_voxel_op(vox_op_t'{func: func_i, x: coord_x_i, y: coord_y_i,
                                       z: coord_z_i, kind: voxel_kind_i});
        answer_q.push_back(got);
        case (func_i)
          FUNC_WRITE: n_writes++;
          FUNC_READ:  n_reads++;
          FUNC_COUNT: begin
            n_counts++;
            if (int'(got.surface_count) > max_surface) max_surface = int'(got.surface_count);
          end
          default:    n_spare++;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (answer_q.size() == 0) begin
          flag_mismatch("result transfer with nothing expected");
        end else begin
          want = answer_q.pop_front();
          if (in_range_o !== want.in_range)
            flag_mismatch($sformatf("result %0d in_range got %b want %b",
                                    n_results, in_range_o, want.in_range));
          if (read_kind_o !== want.read_kind)
            flag_mismatch($sformatf("result %0d read_kind got %0d want %0d",
                                    n_results, read_kind_o, want.read_kind));
          if (surface_count_o !== want.surface_count)
            flag_mismatch($sformatf("result %0d surface_count got %0d want %0d",
                                    n_results, surface_count_o, want.surface_count));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  task automatic cfg_write(logic [1:0] idx, logic [ExtW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PaddrW'({idx, 2'b00});
    pwdata <= PdataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WIDTH:  width_reg = val;
      REG_HEIGHT: height_reg = val;
      default:    depth_reg = val;
    endcase
  endtask

  task automatic set_extents(logic [ExtW-1:0] w, logic [ExtW-1:0] h, logic [ExtW-1:0] d);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_DEPTH, d);
    n_settings++;
  endtask

  task automatic wait_drained();
    while (voxel_ops_q.size() != 0 || in_valid_i || answer_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic queue_op(logic [FuncW-1:0] f, int x, int y, int z, logic [KindW-1:0] k);
    voxel_ops_q.push_back(vox_op_t'{func: f, x: CoordW'(x), y: CoordW'(y), z: CoordW'(z),
                                    kind: k});
  endtask

  // mostly inside the grid, some just past an edge, some anywhere in 16 bits
  function automatic logic signed [CoordW-1:0] rand_coord(int lim);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return CoordW'($urandom);
    if (r < 24 || lim == 0) begin
      case ($urandom_range(3))
        0:       return CoordW'(-1);
        1:       return CoordW'(lim);
        2:       return CoordW'(lim + 1);
        default: return CoordW'(-2);
      endcase
    end
    return CoordW'($urandom_range(lim - 1));
  endfunction

  function automatic logic [KindW-1:0] rand_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return KindW'($urandom_range(7, 5));
    if (r < 28) return KIND_AIR;
    return KindW'($urandom_range(4, 1));
  endfunction

  task automatic load_random(int n, int count_pct);
    int unsigned r;
    vox_op_t op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < count_pct) op.func = FUNC_COUNT;
      else if (r < count_pct + 3) op.func = FUNC_SPARE;
      else if (r < 55) op.func = FUNC_WRITE;
      else op.func = FUNC_READ;
      op.x = rand_coord(span(width_reg, MAX_X));
      op.y = rand_coord(span(height_reg, MAX_Y));
      op.z = rand_coord(span(depth_reg, MAX_Z));
      op.kind = rand_kind();
      voxel_ops_q.push_back(op);
    end
  endtask

  initial begin
    int w, h, d;
    foreach (grid_q[x, y, z]) grid_q[x][y][z] = KIND_AIR;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: edges, ignored kinds, air overwrite, spare op
    send_idle_pct = 30;
    recv_idle_pct = 30;
    set_extents(5, 4, 3);
    queue_op(FUNC_COUNT, 0, 0, 0, KIND_AIR);
    queue_op(FUNC_READ, 0, 0, 0, KIND_AIR);
    queue_op(FUNC_WRITE, 0, 0, 0, KIND_GRASS);
    queue_op(FUNC_WRITE, 4, 3, 2, KIND_WATER);
    queue_op(FUNC_WRITE, 1, 0, 0, KIND_STONE);
    queue_op(FUNC_WRITE, 2, 0, 0, KIND_DIRT);
    queue_op(FUNC_WRITE, 5, 0, 0, KIND_STONE);
    queue_op(FUNC_WRITE, 0, -1, 0, KIND_STONE);
    queue_op(FUNC_WRITE, 0, 0, 3, KIND_STONE);
    queue_op(FUNC_WRITE, 32767, -32768, 0, KIND_STONE);
    queue_op(FUNC_WRITE, 1, 1, 1, 3'd7);
    queue_op(FUNC_WRITE, 1, 0, 0, 3'd5);
    queue_op(FUNC_WRITE, 2, 0, 0, KIND_AIR);
    queue_op(FUNC_READ, 1, 1, 1, KIND_AIR);
    queue_op(FUNC_READ, 1, 0, 0, KIND_AIR);
    queue_op(FUNC_READ, 2, 0, 0, KIND_AIR);
    queue_op(FUNC_READ, 4, 3, 2, KIND_AIR);
    queue_op(FUNC_READ, -32768, -32768, -32768, KIND_AIR);
    queue_op(FUNC_READ, 32767, 32767, 32767, 3'd7);
    queue_op(FUNC_SPARE, 0, 0, 0, KIND_STONE);
    queue_op(FUNC_READ, 0, 0, 0, KIND_AIR);
    queue_op(FUNC_COUNT, 0, 0, 0, KIND_AIR);
    wait_drained();

    // empty grid hides everything
    set_extents(0, 4, 3);
    queue_op(FUNC_WRITE, 0, 0, 0, KIND_STONE);
    queue_op(FUNC_READ, 0, 0, 0, KIND_AIR);
    queue_op(FUNC_COUNT, 0, 0, 0, KIND_AIR);
    wait_drained();

    // oversized width clamps; hidden voxel at the origin comes back
    set_extents(63, 1, 1);
    queue_op(FUNC_WRITE, 31, 0, 0, KIND_DIRT);
    queue_op(FUNC_READ, 0, 0, 0, KIND_AIR);
    queue_op(FUNC_COUNT, 0, 0, 0, KIND_AIR);
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 9) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 25 * $urandom_range(2);
        recv_idle_pct = 25 * $urandom_range(2);
      end
      if (ph == 7) begin
        // whole grid, so earlier hidden voxels take part; counts are long here
        set_extents(32, 63, 32);
        queue_op(FUNC_COUNT, 0, 0, 0, KIND_AIR);
        load_random(38, 0);
        queue_op(FUNC_COUNT, 0, 0, 0, KIND_AIR);
      end else begin
        if (ph == 3) begin
          w = 1;
          h = 1;
          d = 1;
        end else if ($urandom_range(3) == 0) begin
          w = $urandom_range(2, 1);
          h = $urandom_range(2, 1);
          d = $urandom_range(3, 1);
          case ($urandom_range(2))
            0:       w = $urandom_range(1) ? 32 : $urandom_range(63, 33);
            1:       h = $urandom_range(1) ? 32 : $urandom_range(63, 33);
            default: d = $urandom_range(1) ? 32 : $urandom_range(63, 33);
          endcase
        end else begin
          w = $urandom_range(6, 1);
          h = $urandom_range(6, 1);
          d = $urandom_range(6, 1);
        end
        if ($urandom_range(11) == 0) begin
          case ($urandom_range(2))
            0:       w = 0;
            1:       h = 0;
            default: d = 0;
          endcase
        end
        set_extents(ExtW'(w), ExtW'(h), ExtW'(d));
        load_random(120, 8);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d writes, %0d reads, %0d surface counts, %0d unused ops over %0d extents",
             n_writes, n_reads, n_counts, n_spare, n_settings);
    $display("Checked %0d results; largest surface count %0d", n_results, max_surface);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/vsc_pkg.sv
design/vsc_ram.sv
design/vsc_regs.sv
design/voxel_surface_counter_core.sv
design/vsc_checker.sv
tb/sv/tb_voxel_surface_counter_core.sv
